// ===== rtl/scfp_pkg.sv =====
// Shared types, codes and tables for the serial command frame parser.
// No dependencies; every other file of the block but scfp_ifs imports this package.
`timescale 1ns / 1ps

package scfp_pkg;

  localparam logic [7:0] HDR_FIRST   = 8'h55;
  localparam logic [7:0] HDR_SECOND  = 8'hAA;
  localparam logic [7:0] TYPE_CMD    = 8'h00;
  localparam logic [7:0] CMD_PILOT   = 8'h12;
  localparam logic [7:0] CMD_CH_04   = 8'h04;
  localparam logic [7:0] CMD_CH_06   = 8'h06;
  localparam logic [7:0] CMD_CH_08   = 8'h08;
  localparam logic [7:0] CMD_CH_10   = 8'h10;
  localparam logic [7:0] CMD_CH_0A   = 8'h0A;
  localparam logic [7:0] CMD_CH_11   = 8'h11;

  // pilot frame needs type, command, four pilot bytes and the checksum
  localparam int PILOT_MIN_BYTES = 7;
  localparam int HOLD_DEPTH      = 6;
  localparam int REPLY_LEN       = 8;

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SUM  = 3'd1;
  localparam logic [2:0] ST_NOT_CMD  = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_OVERSIZE = 3'd4;

  localparam logic [1:0] CH_NONE = 2'd0;
  localparam logic [1:0] CH_A    = 2'd1;
  localparam logic [1:0] CH_B    = 2'd2;

  // one finished frame, as handed from the parser to the emitter
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  cmd;
    logic [1:0]  chan;
    logic        store;
    logic [15:0] pilot_a;
    logic [15:0] pilot_b;
    logic        reply;
  } frame_desc_t;

  function automatic logic is_chan_cmd(input logic [7:0] cmd);
    logic hit;
    case (cmd) inside
      CMD_CH_04, CMD_CH_06, CMD_CH_08, CMD_CH_10, CMD_CH_0A, CMD_CH_11: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // fixed reply frame 55 AA 04 01 00 01 00 06
  function automatic logic [7:0] reply_rom(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0: val = 8'h55;
      3'd1: val = 8'hAA;
      3'd2: val = 8'h04;
      3'd3: val = 8'h01;
      3'd4: val = 8'h00;
      3'd5: val = 8'h01;
      3'd6: val = 8'h00;
      default: val = 8'h06;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/scfp_ifs.sv =====
// Handshake channels of the serial command frame parser: input bytes,
// result words and the configuration write. No dependencies.
`timescale 1ns / 1ps

interface scfp_rx_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface scfp_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [7:0]  command_code;
  logic [1:0]  channel_select;
  logic        store_request;
  logic [15:0] pilot_word_a;
  logic [15:0] pilot_word_b;
  logic [7:0]  reply_byte;
  logic        last;
  modport source (output valid, kind, status, command_code, channel_select, store_request,
                  pilot_word_a, pilot_word_b, reply_byte, last, input ready);
  modport sink   (input valid, kind, status, command_code, channel_select, store_request,
                  pilot_word_a, pilot_word_b, reply_byte, last, output ready);
endinterface

interface scfp_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/scfp_front.sv =====
// Frame parser: header hunt, length check, payload hold and checksum.
// Depends on scfp_pkg and scfp_rx_if; emits one descriptor per finished or oversize frame.
`timescale 1ns / 1ps

module scfp_front #(
  parameter int MAX_PAYLOAD = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  scfp_rx_if.sink               rx,
  input  logic                  test_mode,
  input  logic                  q_full,
  output logic                  push,
  output scfp_pkg::frame_desc_t desc
);
  import scfp_pkg::*;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  logic [1:0] phase;
  logic [3:0] frame_length;
  logic [3:0] byte_count;
  logic [7:0] running_sum;
  logic [7:0] hold [HOLD_DEPTH];
  logic [7:0] hold_now [HOLD_DEPTH];

  logic       accept;
  logic       is_byte;
  logic [7:0] b;
  logic       oversize;
  logic       data_end;
  logic       short_pilot;

  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;
  assign is_byte  = rx.action == ACT_BYTE;
  assign b        = rx.rx_byte;
  assign oversize = b >= 8'(MAX_PAYLOAD);
  assign data_end = byte_count >= frame_length;
  assign short_pilot = ({1'b0, frame_length} + 5'd1) < 5'(PILOT_MIN_BYTES);

  assign push = accept && is_byte &&
                ((phase == PH_LENGTH && oversize) || (phase == PH_DATA && data_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= '0;
      byte_count   <= '0;
      running_sum  <= '0;
    end else if (accept) begin
      if (!is_byte) begin
        phase      <= PH_HUNT;
        byte_count <= '0;
      end else begin
        unique case (phase)
          PH_HUNT: begin
            if (b == HDR_FIRST) phase <= PH_SECOND;
          end
          PH_SECOND: begin
            if (b == HDR_SECOND) phase <= PH_LENGTH;
            else if (b != HDR_FIRST) phase <= PH_HUNT;
          end
          PH_LENGTH: begin
            if (oversize) begin
              phase <= PH_HUNT;
            end else begin
              frame_length <= b[3:0];
              byte_count   <= '0;
              running_sum  <= b;
              phase        <= PH_DATA;
            end
          end
          default: begin
            if (data_end) begin
              phase      <= PH_HUNT;
              byte_count <= '0;
            end else begin
              running_sum <= running_sum + b;
              byte_count  <= byte_count + 4'd1;
            end
          end
        endcase
      end
    end
  end

  // held bytes are zeroed at every accepted length, so short frames read zeros
  always_ff @(posedge clk) begin
    if (accept && is_byte) begin
      if (phase == PH_LENGTH && !oversize) begin
        for (int i = 0; i < HOLD_DEPTH; i++) hold[i] <= '0;
      end else if (phase == PH_DATA && byte_count < 4'(HOLD_DEPTH)) begin
        hold[byte_count[2:0]] <= b;
      end
    end
  end

  // view of the hold including the byte arriving now
  always_comb begin
    for (int i = 0; i < HOLD_DEPTH; i++)
      hold_now[i] = (byte_count == 4'(i)) ? b : hold[i];
  end

  always_comb begin
    desc = '0;
    if (phase == PH_LENGTH) begin
      desc.status = ST_OVERSIZE;
    end else if (b != running_sum) begin
      desc.status = ST_BAD_SUM;
    end else if (hold_now[0] != TYPE_CMD) begin
      desc.status = ST_NOT_CMD;
      desc.cmd    = hold_now[1];
    end else if (is_chan_cmd(hold_now[1])) begin
      desc.status = ST_OK;
      desc.cmd    = hold_now[1];
      desc.chan   = (hold_now[2] == 8'h00) ? CH_A : CH_B;
    end else if (hold_now[1] == CMD_PILOT) begin
      desc.cmd   = hold_now[1];
      desc.reply = 1'b1;
      if (short_pilot) begin
        desc.status = ST_SHORT;
      end else begin
        desc.status  = ST_OK;
        desc.store   = !test_mode;
        desc.pilot_a = {hold_now[2], hold_now[3]};
        desc.pilot_b = {hold_now[4], hold_now[5]};
      end
    end else begin
      desc.status = ST_OK;
      desc.cmd    = hold_now[1];
    end
  end

endmodule

// ===== rtl/scfp_queue.sv =====
// Two-entry descriptor queue between parser and emitter.
// Depends on scfp_pkg for the descriptor type.
`timescale 1ns / 1ps

module scfp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  scfp_pkg::frame_desc_t push_desc,
  input  logic                  pop,
  output logic                  full,
  output logic                  avail,
  output scfp_pkg::frame_desc_t head
);
  import scfp_pkg::*;

  frame_desc_t slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full  = count == 2'd2;
  assign avail = count != 2'd0;
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/scfp_back.sv =====
// Result emitter: one report word per descriptor, then the reply bytes if it asks for a reply.
// Depends on scfp_pkg and scfp_res_if.
`timescale 1ns / 1ps

module scfp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  avail,
  input  scfp_pkg::frame_desc_t head,
  output logic                  pop,
  scfp_res_if.source            res
);
  import scfp_pkg::*;

  logic        busy;
  frame_desc_t cur;
  logic [3:0]  idx;   // 0 report, 1..REPLY_LEN reply bytes
  logic        is_report;
  logic        fin;
  logic        taken;

  assign is_report = idx == 4'd0;
  assign fin   = (is_report && !cur.reply) || idx == 4'(REPLY_LEN);
  assign taken = res.valid && res.ready;
  assign pop   = avail && (!busy || (taken && fin));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (taken) begin
      if (fin) busy <= 1'b0;
      else idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  wire [3:0] rom_idx = idx - 4'd1;

  assign res.valid          = busy;
  assign res.kind           = is_report ? KIND_REPORT : KIND_REPLY;
  assign res.status         = is_report ? cur.status : ST_OK;
  assign res.command_code   = is_report ? cur.cmd : 8'h00;
  assign res.channel_select = is_report ? cur.chan : CH_NONE;
  assign res.store_request  = is_report && cur.store;
  assign res.pilot_word_a   = is_report ? cur.pilot_a : 16'h0000;
  assign res.pilot_word_b   = is_report ? cur.pilot_b : 16'h0000;
  assign res.reply_byte     = is_report ? 8'h00 : reply_rom(rom_idx[2:0]);
  assign res.last           = fin;

endmodule

// ===== rtl/serial_command_frame_parser_core.sv =====
// Top level of the serial command frame parser: config register, parser,
// descriptor queue and emitter. Depends on scfp_pkg, scfp_ifs and the scfp_* modules.
//
//  channel  dir  word                                     done when
//  rx       in   action, rx_byte                          rx.valid && rx.ready
//  res      out  kind, status, ... reply_byte, last       res.valid && res.ready
//  cfg      in   data -> test_mode                        cfg.valid (ready held high)
//
// One input byte per cycle; rx.ready drops only while the two-entry queue is full.
// Each frame drains as 1 report word, plus 8 reply words for a pilot command,
// so the emitter's word counter sets the sustained frame rate.
// Synchronous reset clears parser phase, queue and emitter; held payload is unreset.
// A stalled res side holds its word and backs up into the queue, then into rx.
`timescale 1ns / 1ps

module serial_command_frame_parser_core #(
  parameter int MAX_PAYLOAD = 10
) (
  input  logic        clk,
  input  logic        rst,
  scfp_rx_if.sink     rx,
  scfp_res_if.source  res,
  scfp_cfg_if.sink    cfg
);
  import scfp_pkg::*;

  logic        test_mode;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_avail;
  frame_desc_t f_desc;
  frame_desc_t q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) test_mode <= 1'b0;
    else if (cfg.valid && cfg.ready) test_mode <= cfg.data;
  end

  scfp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .test_mode (test_mode),
    .q_full    (q_full),
    .push      (q_push),
    .desc      (f_desc)
  );

  scfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (f_desc),
    .pop       (q_pop),
    .full      (q_full),
    .avail     (q_avail),
    .head      (q_head)
  );

  scfp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (q_avail),
    .head  (q_head),
    .pop   (q_pop),
    .res   (res)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("descriptor pushed into full queue");

  a_reply_tail: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_REPLY && res.last) |-> res.reply_byte == 8'h06)
    else $error("reply frame did not end on its final byte");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid right after reset");
`endif

endmodule
